[rtl/bdhe_pkg.sv]
package bdhe_pkg;

    // Field widths of one sample and one result
    localparam int IDX_W       = 3;
    localparam int NOW_W       = 32;
    localparam int HOLD_W      = 16;
    localparam int LEVEL_W     = 8;
    localparam int KINDS       = 5;
    localparam int ENABLE_W    = 40;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 3'd0,
        CFG_SHORT_HOLD   = 3'd1,
        CFG_LONG_HOLD    = 3'd2,
        CFG_PRESSED_LVL  = 3'd3,
        CFG_EVENT_ENABLE = 3'd4,
        CFG_BUTTON_COUNT = 3'd5
    } cfg_reg_e;

    // Position of each event kind inside a button's five enable bits
    localparam int KIND_DOWN  = 0;
    localparam int KIND_UP    = 1;
    localparam int KIND_PRESS = 2;
    localparam int KIND_SHORT = 3;
    localparam int KIND_LONG  = 4;

    // Bit positions in the result tdata
    localparam int OUT_DOWN_BIT  = 3;
    localparam int OUT_UP_BIT    = 4;
    localparam int OUT_PRESS_BIT = 5;
    localparam int OUT_SHORT_BIT = 6;
    localparam int OUT_LONG_BIT  = 7;
    localparam int OUT_HELD_BIT  = 8;
    localparam int OUT_USED_W    = 9;

    // Event flags of one result
    typedef struct packed {
        logic held;
        logic long_ev;
        logic short_ev;
        logic press_ev;
        logic up_ev;
        logic down_ev;
    } ev_flags_t;

endpackage

[rtl/bdhe_ram.sv]
module bdhe_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/button_debounce_hold_events.sv]
// Channel   | Dir | Transaction         | tdata fields (low bit up)
// ----------+-----+---------------------+-------------------------------------------
// s_axis    | in  | one button sample   | btn_num[2:0] pin_level[3] now_ms[35:4]
// m_axis    | out | one result / sample | event_button[2:0] down up press short long
//           |     |                     | held_stable[8]
// cfg       | in  | register write      | cfg_index selects, cfg_wdata carries value
//
// One sample per clock sustained while m_axis_tready is high. The per-button state
// RAM is read on acceptance, the update stage updates it and writes it back,
// and the result sits in an output register. A write-back bypass covers a
// sample that reads the entry the previous sample is writing. Reset clears
// the entry valid flags at once, so no clearing pass is needed. A stalled
// output register holds the update stage, which in turn holds s_axis_tready.
module button_debounce_hold_events #(
    parameter int NUM_BUTTONS = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // btn_num[2:0], pin_level[3], now_ms[35:4], zero pad
    input  logic [bdhe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // event_button[2:0], down[3], up[4], press[5], short[6], long[7], held_stable[8]
    output logic [bdhe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [bdhe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdhe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ADDR_W = NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1;
    // Entry layout: {long_done, short_done, down_done, stable, seen, start}
    localparam int ENT_W  = TIME_BITS + 5;
    localparam int SEEN_B = TIME_BITS;
    localparam int STAB_B = TIME_BITS + 1;
    localparam int DOWN_B = TIME_BITS + 2;
    localparam int SHRT_B = TIME_BITS + 3;
    localparam int LONG_B = TIME_BITS + 4;

    // Configuration registers
    logic [bdhe_pkg::HOLD_W-1:0]   debounce_reg;
    logic [bdhe_pkg::HOLD_W-1:0]   short_hold_reg;
    logic [bdhe_pkg::HOLD_W-1:0]   long_hold_reg;
    logic [bdhe_pkg::LEVEL_W-1:0]  pressed_level_reg;
    logic [bdhe_pkg::ENABLE_W-1:0] event_enable_reg;
    logic [bdhe_pkg::COUNT_W-1:0]  button_count_reg;

    // Update stage
    logic                          s1_valid_reg;
    logic [bdhe_pkg::IDX_W-1:0]    s1_idx_reg;
    logic                          s1_level_reg;
    logic [bdhe_pkg::NOW_W-1:0]    s1_now_reg;

    // Write-back bypass and entry valid flags
    logic                          wb_valid_reg;
    logic [ADDR_W-1:0]             wb_addr_reg;
    logic [ENT_W-1:0]              wb_data_reg;
    logic [NUM_BUTTONS-1:0]        ent_valid_reg;

    // Output register
    logic                              out_valid_reg;
    logic [bdhe_pkg::OUT_TDATA_W-1:0]  out_data_reg;
    logic [bdhe_pkg::OUT_TDATA_W-1:0]  out_data_next;

    logic                          accept;
    logic                          s1_advance;
    logic [bdhe_pkg::IDX_W-1:0]    in_idx;
    logic [5:0]                    in_idx_ext;
    logic [ADDR_W-1:0]             rd_addr;
    logic [5:0]                    s1_idx_ext;
    logic [ADDR_W-1:0]             s1_addr;
    logic [ENT_W-1:0]              ram_rdata;
    logic [ENT_W-1:0]              ent_cur;
    logic [ENT_W-1:0]              ent_next;
    logic                          in_use;
    logic                          wr_en;

    logic [63:0]                   now_wide;
    logic [63:0]                   deb_wide;
    logic [63:0]                   shrt_wide;
    logic [63:0]                   long_wide;
    logic [TIME_BITS-1:0]          now_t;
    logic [TIME_BITS-1:0]          delta;
    logic [bdhe_pkg::KINDS-1:0]    ev_en;
    logic                          pressed;
    logic                          over_deb;
    bdhe_pkg::ev_flags_t           flags;

    // Handshake
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_idx     = s_axis_tdata[2:0];
    assign in_idx_ext = {3'b000, in_idx};
    assign rd_addr    = in_idx_ext[ADDR_W-1:0];
    assign s1_idx_ext = {3'b000, s1_idx_reg};
    assign s1_addr    = s1_idx_ext[ADDR_W-1:0];

    bdhe_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (ent_next),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= 16'd50;
            short_hold_reg    <= 16'd1000;
            long_hold_reg     <= 16'd3000;
            pressed_level_reg <= '0;
            event_enable_reg  <= '0;
            button_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (bdhe_pkg::cfg_reg_e'(cfg_index))
                bdhe_pkg::CFG_DEBOUNCE:     debounce_reg      <= cfg_wdata[15:0];
                bdhe_pkg::CFG_SHORT_HOLD:   short_hold_reg    <= cfg_wdata[15:0];
                bdhe_pkg::CFG_LONG_HOLD:    long_hold_reg     <= cfg_wdata[15:0];
                bdhe_pkg::CFG_PRESSED_LVL:  pressed_level_reg <= cfg_wdata[7:0];
                bdhe_pkg::CFG_EVENT_ENABLE: event_enable_reg  <= cfg_wdata[39:0];
                bdhe_pkg::CFG_BUTTON_COUNT: button_count_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Current entry: bypass of the last write, else RAM, else reset value
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr))
        begin
            ent_cur = wb_data_reg;
        end
        else if (ent_valid_reg[s1_addr])
        begin
            ent_cur = ram_rdata;
        end
        else
        begin
            ent_cur = '0;
        end
    end

    // Time arithmetic at TIME_BITS
    assign now_wide  = {32'd0, s1_now_reg};
    assign deb_wide  = {48'd0, debounce_reg};
    assign shrt_wide = {48'd0, short_hold_reg};
    assign long_wide = {48'd0, long_hold_reg};
    assign now_t     = now_wide[TIME_BITS-1:0];
    assign delta     = now_t - ent_cur[TIME_BITS-1:0];
    assign over_deb  = delta > deb_wide[TIME_BITS-1:0];

    assign in_use  = ({1'b0, s1_idx_reg} < button_count_reg)
                     && (s1_idx_ext < 6'(NUM_BUTTONS));
    assign pressed = s1_level_reg == pressed_level_reg[s1_idx_reg];
    assign ev_en   = event_enable_reg[s1_idx_ext * 6'd5 +: bdhe_pkg::KINDS];

    // Per-button state update and events
    always_comb
    begin
        ent_next = ent_cur;
        flags    = '0;
        if (ent_cur[SEEN_B])
        begin
            if (pressed)
            begin
                if (over_deb)
                begin
                    ent_next[STAB_B] = 1'b1;
                    flags.down_ev    = !ent_cur[DOWN_B] && ev_en[bdhe_pkg::KIND_DOWN];
                    ent_next[DOWN_B] = 1'b1;
                end
                else
                begin
                    ent_next[STAB_B] = 1'b0;
                end
            end
            else
            begin
                if (over_deb)
                begin
                    flags.up_ev    = ev_en[bdhe_pkg::KIND_UP];
                    flags.press_ev = (delta < shrt_wide[TIME_BITS-1:0])
                                     && ev_en[bdhe_pkg::KIND_PRESS];
                end
                ent_next[SEEN_B] = 1'b0;
                ent_next[STAB_B] = 1'b0;
                ent_next[DOWN_B] = 1'b0;
                ent_next[SHRT_B] = 1'b0;
                ent_next[LONG_B] = 1'b0;
            end
        end
        else if (pressed)
        begin
            ent_next[SEEN_B]          = 1'b1;
            ent_next[TIME_BITS-1:0]   = now_t;
        end

        // Hold thresholds while stable
        if (ent_next[STAB_B])
        begin
            if (!ent_next[SHRT_B] && (delta > shrt_wide[TIME_BITS-1:0]))
            begin
                flags.short_ev   = ev_en[bdhe_pkg::KIND_SHORT];
                ent_next[SHRT_B] = 1'b1;
            end
            if (!ent_next[LONG_B] && (delta > long_wide[TIME_BITS-1:0]))
            begin
                flags.long_ev    = ev_en[bdhe_pkg::KIND_LONG];
                ent_next[LONG_B] = 1'b1;
            end
        end
        flags.held = ent_next[STAB_B];

        if (!in_use)
        begin
            flags = '0;
        end
    end

    assign wr_en = s1_advance && in_use;

    // Result word
    always_comb
    begin
        out_data_next                          = '0;
        out_data_next[2:0]                     = s1_idx_reg;
        out_data_next[bdhe_pkg::OUT_DOWN_BIT]  = flags.down_ev;
        out_data_next[bdhe_pkg::OUT_UP_BIT]    = flags.up_ev;
        out_data_next[bdhe_pkg::OUT_PRESS_BIT] = flags.press_ev;
        out_data_next[bdhe_pkg::OUT_SHORT_BIT] = flags.short_ev;
        out_data_next[bdhe_pkg::OUT_LONG_BIT]  = flags.long_ev;
        out_data_next[bdhe_pkg::OUT_HELD_BIT]  = flags.held;
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            ent_valid_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (wr_en)
            begin
                wb_valid_reg           <= 1'b1;
                ent_valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= in_idx;
            s1_level_reg <= s_axis_tdata[3];
            s1_now_reg   <= s_axis_tdata[35:4];
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
        if (wr_en)
        begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= ent_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/bdhe_checker.sv]
module bdhe_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bdhe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic held;
    logic down_ev;
    logic up_ev;
    logic press_ev;
    logic hold_ev;

    assign held     = m_axis_tdata[bdhe_pkg::OUT_HELD_BIT];
    assign down_ev  = m_axis_tdata[bdhe_pkg::OUT_DOWN_BIT];
    assign up_ev    = m_axis_tdata[bdhe_pkg::OUT_UP_BIT];
    assign press_ev = m_axis_tdata[bdhe_pkg::OUT_PRESS_BIT];
    assign hold_ev  = m_axis_tdata[bdhe_pkg::OUT_SHORT_BIT]
                      || m_axis_tdata[bdhe_pkg::OUT_LONG_BIT];

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A new result traces back to an input transaction through the update stage and output register
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding input transaction");

    // Down and hold events only come from a stable press
    a_stable_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (down_ev || hold_ev) |-> held)
        else $error("down or hold event without stable press");

    // Release events leave the button unstable and never pair with down
    a_release_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (up_ev || press_ev) |-> !held && !down_ev)
        else $error("release event with stable press or down");

endmodule

bind button_debounce_hold_events bdhe_checker u_bdhe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_button_debounce_hold_events.sv]
module tb_button_debounce_hold_events;

    localparam int NBTN         = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SEGMENTS     = 9;
    localparam int SEG_ITEMS    = 200;
    localparam int DIR_ROWS     = 38;
    localparam int TAIL_CYCLES  = 8;

    // One result as it sits in m_axis_tdata[8:0]
    typedef struct packed {
        bdhe_pkg::ev_flags_t        flags;
        logic [bdhe_pkg::IDX_W-1:0] button;
    } result_t;

    // Directed stimulus row: a register write or one sample
    typedef struct packed {
        logic                            is_cfg;
        bdhe_pkg::cfg_reg_e              sel;
        logic [bdhe_pkg::CFG_DATA_W-1:0] value;
        logic [bdhe_pkg::IDX_W-1:0]      idx;
        logic                            lvl;
        logic [bdhe_pkg::NOW_W-1:0]      now;
        logic                            typed;
        bdhe_pkg::ev_flags_t             want;
    } step_row_t;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic [bdhe_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [bdhe_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic                             cfg_we        = 1'b0;
    logic [bdhe_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [bdhe_pkg::CFG_DATA_W-1:0]  cfg_wdata     = '0;

    // Register copies, reset values
    logic [bdhe_pkg::HOLD_W-1:0]   cfg_debounce = 16'd50;
    logic [bdhe_pkg::HOLD_W-1:0]   cfg_short    = 16'd1000;
    logic [bdhe_pkg::HOLD_W-1:0]   cfg_long     = 16'd3000;
    logic [bdhe_pkg::LEVEL_W-1:0]  cfg_level    = '0;
    logic [bdhe_pkg::ENABLE_W-1:0] cfg_enable   = '0;
    logic [bdhe_pkg::COUNT_W-1:0]  cfg_count    = '0;

    // Per-button tracking state
    logic [NBTN-1:0]            seen       = '0;
    logic [NBTN-1:0]            stable     = '0;
    logic [NBTN-1:0]            down_done  = '0;
    logic [NBTN-1:0]            short_done = '0;
    logic [NBTN-1:0]            long_done  = '0;
    logic [bdhe_pkg::NOW_W-1:0] start_ms [NBTN];

    result_t awaited[$];

    int send_idle_pct  = 11;
    int recv_stall_pct = 72;
    int fail_count     = 0;
    int cycle_count    = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int n_down = 0, n_up = 0, n_press = 0, n_short = 0, n_long = 0;

    button_debounce_hold_events DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected result of one sample; updates the tracked button state
    function automatic result_t track_button(input logic [bdhe_pkg::IDX_W-1:0] idx,
                                             input logic lvl,
                                             input logic [bdhe_pkg::NOW_W-1:0] now);
        result_t                    r;
        int                         in_use;
        logic                       pressed;
        logic [bdhe_pkg::NOW_W-1:0] held_ms;
        logic [bdhe_pkg::NOW_W-1:0] deb_ms;
        logic [bdhe_pkg::NOW_W-1:0] shrt_ms;
        logic [bdhe_pkg::NOW_W-1:0] long_ms;
        r = '0;
        r.button = idx;
        deb_ms  = {{(bdhe_pkg::NOW_W-bdhe_pkg::HOLD_W){1'b0}}, cfg_debounce};
        shrt_ms = {{(bdhe_pkg::NOW_W-bdhe_pkg::HOLD_W){1'b0}}, cfg_short};
        long_ms = {{(bdhe_pkg::NOW_W-bdhe_pkg::HOLD_W){1'b0}}, cfg_long};
        in_use = (int'(cfg_count) > NBTN) ? NBTN : int'(cfg_count);
        if (int'(idx) < in_use)
        begin
            pressed = (lvl == cfg_level[idx]);
            held_ms = now - start_ms[idx];
            if (seen[idx])
            begin
                if (pressed)
                begin
                    if (held_ms > deb_ms)
                    begin
                        stable[idx] = 1'b1;
                        if (!down_done[idx]
                            && cfg_enable[idx*bdhe_pkg::KINDS + bdhe_pkg::KIND_DOWN])
                            r.flags.down_ev = 1'b1;
                        down_done[idx] = 1'b1;
                    end
                    else
                        stable[idx] = 1'b0;
                end
                else
                begin
                    // release: up after debounce, press if shorter than short hold
                    if (held_ms > deb_ms)
                    begin
                        r.flags.up_ev = cfg_enable[idx*bdhe_pkg::KINDS + bdhe_pkg::KIND_UP];
                        if (held_ms < shrt_ms
                            && cfg_enable[idx*bdhe_pkg::KINDS + bdhe_pkg::KIND_PRESS])
                            r.flags.press_ev = 1'b1;
                    end
                    seen[idx]       = 1'b0;
                    stable[idx]     = 1'b0;
                    down_done[idx]  = 1'b0;
                    short_done[idx] = 1'b0;
                    long_done[idx]  = 1'b0;
                end
            end
            else if (pressed)
            begin
                seen[idx]     = 1'b1;
                start_ms[idx] = now;
            end
            // hold events, once per press even when masked
            if (stable[idx])
            begin
                if (!short_done[idx] && held_ms > shrt_ms)
                begin
                    r.flags.short_ev = cfg_enable[idx*bdhe_pkg::KINDS + bdhe_pkg::KIND_SHORT];
                    short_done[idx]  = 1'b1;
                end
                if (!long_done[idx] && held_ms > long_ms)
                begin
                    r.flags.long_ev = cfg_enable[idx*bdhe_pkg::KINDS + bdhe_pkg::KIND_LONG];
                    long_done[idx]  = 1'b1;
                end
            end
            r.flags.held = stable[idx];
        end
        return r;
    endfunction

    function automatic step_row_t cfg_row(input bdhe_pkg::cfg_reg_e sel,
                                          input logic [bdhe_pkg::CFG_DATA_W-1:0] value);
        step_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.sel    = sel;
        row.value  = value;
        return row;
    endfunction

    // want bits, high to low: held, long, short, press, up, down
    function automatic step_row_t smp_exp(input logic [bdhe_pkg::IDX_W-1:0] idx,
                                          input logic lvl,
                                          input logic [bdhe_pkg::NOW_W-1:0] now,
                                          input bdhe_pkg::ev_flags_t want);
        step_row_t row;
        row = '0;
        row.idx   = idx;
        row.lvl   = lvl;
        row.now   = now;
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic step_row_t smp_row(input logic [bdhe_pkg::IDX_W-1:0] idx,
                                          input logic lvl,
                                          input logic [bdhe_pkg::NOW_W-1:0] now);
        step_row_t row;
        row = smp_exp(idx, lvl, now, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Register write; only issued while the block is drained
    task automatic write_reg(input bdhe_pkg::cfg_reg_e sel,
                             input logic [bdhe_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (sel)
            bdhe_pkg::CFG_DEBOUNCE:     cfg_debounce = value[bdhe_pkg::HOLD_W-1:0];
            bdhe_pkg::CFG_SHORT_HOLD:   cfg_short    = value[bdhe_pkg::HOLD_W-1:0];
            bdhe_pkg::CFG_LONG_HOLD:    cfg_long     = value[bdhe_pkg::HOLD_W-1:0];
            bdhe_pkg::CFG_PRESSED_LVL:  cfg_level    = value[bdhe_pkg::LEVEL_W-1:0];
            bdhe_pkg::CFG_EVENT_ENABLE: cfg_enable   = value[bdhe_pkg::ENABLE_W-1:0];
            bdhe_pkg::CFG_BUTTON_COUNT: cfg_count    = value[bdhe_pkg::COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One sample transaction, with random gaps ahead of it
    task automatic send_sample(input logic [bdhe_pkg::IDX_W-1:0] idx, input logic lvl,
                               input logic [bdhe_pkg::NOW_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {{(bdhe_pkg::IN_TDATA_W-bdhe_pkg::IDX_W-1-bdhe_pkg::NOW_W){1'b0}},
                          now, lvl, idx};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Result side: random back-pressure, timeout, field compare
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        cycle_count++;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[bdhe_pkg::OUT_USED_W-1:0];
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("result for button %0d with nothing awaited", got.button);
                fail_count++;
            end
            else
            begin
                want = awaited.pop_front();
                check_field("event_button", int'(want.button), int'(got.button));
                check_field("down_event", int'(want.flags.down_ev),
                            int'(got.flags.down_ev));
                check_field("up_event", int'(want.flags.up_ev), int'(got.flags.up_ev));
                check_field("press_event", int'(want.flags.press_ev),
                            int'(got.flags.press_ev));
                check_field("short_event", int'(want.flags.short_ev),
                            int'(got.flags.short_ev));
                check_field("long_event", int'(want.flags.long_ev),
                            int'(got.flags.long_ev));
                check_field("held_stable", int'(want.flags.held), int'(got.flags.held));
            end
            n_down  += int'(got.flags.down_ev);
            n_up    += int'(got.flags.up_ev);
            n_press += int'(got.flags.press_ev);
            n_short += int'(got.flags.short_ev);
            n_long  += int'(got.flags.long_ev);
        end
    end

    initial
    begin : stimulus
        step_row_t                       dir_table [DIR_ROWS];
        result_t                         r;
        int                              seg;
        int                              used;
        int                              in_use;
        int                              step_max;
        logic [bdhe_pkg::IDX_W-1:0]      b;
        logic                            lvl;
        logic [bdhe_pkg::NOW_W-1:0]      now;
        logic [bdhe_pkg::NOW_W-1:0]      clock_ms;
        logic [NBTN-1:0]                 want_down;
        logic [bdhe_pkg::HOLD_W-1:0]     dbn, shrt, lng;
        logic [bdhe_pkg::CFG_DATA_W-1:0] ena;
        logic [bdhe_pkg::COUNT_W-1:0]    cnt;

        for (int i = 0; i < NBTN; i++)
            start_ms[i] = '0;
        want_down = '0;

        dir_table = '{
            smp_exp(3'd0, 1'b0, 32'd0, 6'b000000),          // nothing in use after reset
            cfg_row(bdhe_pkg::CFG_DEBOUNCE, 40'd10),
            cfg_row(bdhe_pkg::CFG_SHORT_HOLD, 40'd100),
            cfg_row(bdhe_pkg::CFG_LONG_HOLD, 40'd200),
            cfg_row(bdhe_pkg::CFG_PRESSED_LVL, 40'h0F),
            cfg_row(bdhe_pkg::CFG_EVENT_ENABLE, 40'hFF_FFFF_FFFF),
            cfg_row(bdhe_pkg::CFG_BUTTON_COUNT, 40'd15),    // oversized count
            smp_exp(3'd0, 1'b1, 32'd1000, 6'b000000),       // press seen
            smp_exp(3'd0, 1'b1, 32'd1011, 6'b100001),       // stable, down
            smp_exp(3'd0, 1'b1, 32'd1101, 6'b101000),       // short hold
            smp_exp(3'd0, 1'b1, 32'd1201, 6'b110000),       // long hold
            smp_exp(3'd0, 1'b0, 32'd1300, 6'b000010),       // up, too long for press
            smp_exp(3'd4, 1'b0, 32'hFFFF_FFF0, 6'b000000),  // active-low button
            smp_exp(3'd4, 1'b1, 32'h0000_0010, 6'b000110),  // time wraps: up and press
            smp_exp(3'd5, 1'b1, 32'd5, 6'b000000),          // release with no press
            smp_exp(3'd7, 1'b0, 32'd50, 6'b000000),
            smp_exp(3'd7, 1'b0, 32'd55, 6'b000000),         // still bouncing
            smp_exp(3'd7, 1'b1, 32'd58, 6'b000000),         // released inside debounce
            smp_exp(3'd6, 1'b0, 32'hFFFF_FFFF, 6'b000000),
            smp_row(3'd6, 1'b1, 32'd5),
            cfg_row(bdhe_pkg::CFG_DEBOUNCE, 40'd0),
            cfg_row(bdhe_pkg::CFG_SHORT_HOLD, 40'd0),
            cfg_row(bdhe_pkg::CFG_LONG_HOLD, 40'd0),
            smp_exp(3'd2, 1'b1, 32'd0, 6'b000000),
            smp_exp(3'd2, 1'b1, 32'd1, 6'b111001),          // all at once with zero times
            cfg_row(bdhe_pkg::CFG_EVENT_ENABLE, 40'd0),
            smp_exp(3'd2, 1'b0, 32'd2, 6'b000000),          // masked up
            smp_exp(3'd1, 1'b1, 32'd7, 6'b000000),
            smp_exp(3'd1, 1'b1, 32'd9, 6'b100000),          // stable, all events masked
            cfg_row(bdhe_pkg::CFG_DEBOUNCE, 40'hFFFF),
            cfg_row(bdhe_pkg::CFG_SHORT_HOLD, 40'hFFFF),
            cfg_row(bdhe_pkg::CFG_LONG_HOLD, 40'hFFFF),
            smp_row(3'd1, 1'b1, 32'd65545),
            smp_exp(3'd1, 1'b0, 32'd65546, 6'b000000),
            cfg_row(bdhe_pkg::CFG_PRESSED_LVL, 40'hFF),
            cfg_row(bdhe_pkg::CFG_BUTTON_COUNT, 40'd3),
            smp_exp(3'd3, 1'b1, 32'd100, 6'b000000),        // index above count
            smp_row(3'd2, 1'b1, 32'd100)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_table[i].is_cfg)
            begin
                wait_drained();
                write_reg(dir_table[i].sel, dir_table[i].value);
            end
            else
            begin
                send_sample(dir_table[i].idx, dir_table[i].lvl, dir_table[i].now);
                r = track_button(dir_table[i].idx, dir_table[i].lvl, dir_table[i].now);
                if (dir_table[i].typed)
                    r.flags = dir_table[i].want;
                awaited.push_back(r);
            end
        end

        // Random press/release sequences, new settings per segment
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            send_idle_pct  = (seg < 3) ? 11 : (seg < 6) ? 72 : 0;
            recv_stall_pct = (seg < 3) ? 72 : (seg < 6) ? 11 : 0;

            if (seg == 4)
            begin
                dbn  = '1;
                shrt = '1;
                lng  = '1;
            end
            else if (seg == 7)
            begin
                dbn  = '0;
                shrt = '0;
                lng  = '0;
            end
            else
            begin
                dbn = 16'($urandom_range(0, 30));
                if ($urandom_range(3) == 0)
                begin
                    shrt = 16'($urandom_range(0, 300));
                    lng  = 16'($urandom_range(0, 300));
                end
                else
                begin
                    shrt = 16'(dbn + $urandom_range(0, 150));
                    lng  = 16'(shrt + $urandom_range(0, 300));
                end
            end
            ena = 40'({$urandom, $urandom});
            if ($urandom_range(1) == 0)
                ena = '1;
            cnt = (seg == 4 || $urandom_range(1) == 0) ? 4'd8 : 4'($urandom_range(1, 15));

            write_reg(bdhe_pkg::CFG_DEBOUNCE, 40'(dbn));
            write_reg(bdhe_pkg::CFG_SHORT_HOLD, 40'(shrt));
            write_reg(bdhe_pkg::CFG_LONG_HOLD, 40'(lng));
            write_reg(bdhe_pkg::CFG_PRESSED_LVL, 40'($urandom_range(0, 255)));
            write_reg(bdhe_pkg::CFG_EVENT_ENABLE, ena);
            write_reg(bdhe_pkg::CFG_BUTTON_COUNT, 40'(cnt));

            in_use   = (int'(cfg_count) > NBTN) ? NBTN : int'(cfg_count);
            // time step sized so holds straddle the thresholds
            step_max = int'(cfg_long) / (2 * in_use) + 2;
            clock_ms = ($urandom_range(1) == 0) ? $urandom
                                                : 32'hFFFF_FFFF - $urandom_range(0, 100000);
            used = 0;
            while (used < SEG_ITEMS)
            begin
                b = ($urandom_range(9) == 0) ? 3'($urandom_range(NBTN - 1))
                                             : 3'($urandom_range(in_use - 1));
                clock_ms += $urandom_range(0, step_max);
                if ($urandom_range(7) == 0)
                    want_down[b] = ~want_down[b];
                lvl = want_down[b] ? cfg_level[b] : ~cfg_level[b];
                now = clock_ms;
                // stray level and time
                if ($urandom_range(11) == 0)
                begin
                    lvl = 1'($urandom_range(1));
                    now = $urandom;
                end
                send_sample(b, lvl, now);
                awaited.push_back(track_button(b, lvl, now));
                if (int'(b) < in_use)
                    used++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d button samples across %0d register writes; %0d results compared.",
                 samples_sent, reg_writes, results_seen);
        $display("Events seen: down %0d, up %0d, press %0d, short %0d, long %0d.",
                 n_down, n_up, n_press, n_short, n_long);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
